@@ sv/prd_pkg.sv @@
// Package: shared types, constants and the CRC step for the packet receive deframer.
package prd_pkg;

   // Reset values of the configuration registers
   localparam logic [7:0]  PREAMBLE_RESET      = 8'd90;
   localparam logic [15:0] TIMEOUT_RESET       = 16'd100;
   localparam logic [1:0]  ACK_CODE_RESET      = 2'd0;
   localparam logic [1:0]  NACK_CODE_RESET     = 2'd1;
   localparam logic [1:0]  REQ_ACK_CODE_RESET  = 2'd3;
   localparam logic [7:0]  ERR_STRAY_RESET     = 8'd1;
   localparam logic [7:0]  ERR_CRC_RESET       = 8'd2;
   localparam logic [7:0]  ERR_TIMEOUT_RESET   = 8'd3;

   // Configuration register indexes
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PREAMBLE     = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TIMEOUT      = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ACK_CODE     = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NACK_CODE    = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REQ_ACK_CODE = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ERR_STRAY    = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ERR_CRC      = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ERR_TIMEOUT  = 3'd7;

   // Result kinds
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_VERDICT = 2'd1;
   localparam logic [1:0] KIND_TX      = 2'd2;

   localparam logic [15:0] CRC_INIT         = 16'hffff;
   localparam int          TICK_WIDTH_DEF   = 16;
   localparam int          JOB_QUEUE_DEPTH  = 4;

   typedef enum logic [2:0] {
      ST_PRE,
      ST_GARBAGE,
      ST_HHI,
      ST_HLO,
      ST_DATA,
      ST_CHI,
      ST_CLO
   } parse_state_type;

   typedef enum logic [1:0] {
      RESP_NONE,
      RESP_NACK,
      RESP_ACK
   } resp_type;

   typedef struct packed {
      logic [7:0]  preamble;
      logic [15:0] timeout_ticks;
      logic [1:0]  ack_code;
      logic [1:0]  nack_code;
      logic [1:0]  req_ack_code;
      logic [7:0]  err_stray;
      logic [7:0]  err_crc;
      logic [7:0]  err_timeout;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      preamble:      PREAMBLE_RESET,
      timeout_ticks: TIMEOUT_RESET,
      ack_code:      ACK_CODE_RESET,
      nack_code:     NACK_CODE_RESET,
      req_ack_code:  REQ_ACK_CODE_RESET,
      err_stray:     ERR_STRAY_RESET,
      err_crc:       ERR_CRC_RESET,
      err_timeout:   ERR_TIMEOUT_RESET
   };

   // One unit of work handed from the parser to the result sequencer
   typedef struct packed {
      logic        is_payload;   // single payload byte result
      logic        has_verdict;  // verdict result comes first
      resp_type    resp;         // response frame that follows
      logic [7:0]  data;         // payload byte or NACK error byte
      logic [1:0]  ptype;
      logic [3:0]  seq;
      logic [9:0]  length;
      logic        good;
   } job_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] byte_value;
      logic [1:0] packet_type;
      logic [3:0] sequence_res;
      logic [9:0] payload_length;
      logic       crc_good;
      logic       last;
   } result_type;

   // CRC-16-CCITT, one byte, byte-swapped table-free form
   function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] d);
      logic [15:0] c;
      c = {crc[7:0], crc[15:8]};
      c = c ^ {8'h00, d};
      c = c ^ {12'h000, c[7:4]};
      c = c ^ {c[3:0], 12'h000};
      c = c ^ {3'b000, c[7:0], 5'b00000};
      return c;
   endfunction

endpackage

@@ sv/prd_ifs.sv @@
// Interfaces: request and response channels of the packet receive deframer.
interface prd_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] rx_byte;

   modport source (output valid, command, rx_byte, input ready);
   modport sink   (input valid, command, rx_byte, output ready);
endinterface

interface prd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] byte_value;
   logic [1:0] packet_type;
   logic [3:0] sequence_res;
   logic [9:0] payload_length;
   logic       crc_good;
   logic       last;

   modport source (output valid, kind, byte_value, packet_type, sequence_res,
                   payload_length, crc_good, last, input ready);
   modport sink   (input valid, kind, byte_value, packet_type, sequence_res,
                   payload_length, crc_good, last, output ready);
endinterface

@@ sv/prd_front.sv @@
// Front end: frame parser, CRC check and receive timer; issues jobs to the queue.
module prd_front #(
   parameter int TICK_WIDTH = prd_pkg::TICK_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   prd_req_if.sink          req_ch,
   input  prd_pkg::cfg_type cfg,
   input  logic             q_full,
   output logic             job_push,
   output prd_pkg::job_type job
);

   localparam logic [31:0] TICK_LIMIT =
      (TICK_WIDTH >= 32) ? 32'hffff_ffff : ((32'd1 << TICK_WIDTH) - 32'd1);

   prd_pkg::parse_state_type state_ff, state_in;
   logic [1:0]            ftype_ff, ftype_in;
   logic [3:0]            fseq_ff, fseq_in;
   logic [9:0]            flen_ff, flen_in;
   logic [9:0]            seen_ff, seen_in;
   logic [15:0]           crc_ff, crc_in;
   logic [7:0]            crc_high_ff, crc_high_in;
   logic [TICK_WIDTH-1:0] left_ff, left_in;
   logic                  armed_ff, armed_in;

   logic                  accept;
   logic                  tick_fire;
   logic [TICK_WIDTH-1:0] timeout_load;
   logic                  crc_match;
   logic [7:0]            c;

   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign c            = req_ch.rx_byte;
   assign crc_match    = ({crc_high_ff, c} == crc_ff);
   // armed timer runs out on this tick
   assign tick_fire    = armed_ff && (left_ff <= TICK_WIDTH'(1));

   // Timer load value, saturated to the counter width
   assign timeout_load = ({16'h0000, cfg.timeout_ticks} > TICK_LIMIT) ?
                         TICK_LIMIT[TICK_WIDTH-1:0] :
                         TICK_WIDTH'({16'h0000, cfg.timeout_ticks});

   // Parser next state
   always_comb begin
      state_in = state_ff;
      if (accept) begin
         if (req_ch.command) begin
            if (tick_fire) state_in = prd_pkg::ST_PRE;
         end else begin
            case (state_ff)
               prd_pkg::ST_PRE: begin
                  if (c == cfg.preamble) state_in = prd_pkg::ST_HHI;
                  else                   state_in = prd_pkg::ST_GARBAGE;
               end
               prd_pkg::ST_GARBAGE: begin
                  if (c == cfg.preamble) state_in = prd_pkg::ST_HHI;
               end
               prd_pkg::ST_HHI: begin
                  state_in = (c[1:0] == 2'b00) ? prd_pkg::ST_CHI : prd_pkg::ST_HLO;
               end
               prd_pkg::ST_HLO: begin
                  state_in = prd_pkg::ST_DATA;
               end
               prd_pkg::ST_DATA: begin
                  if (seen_ff + 10'd1 >= flen_ff) state_in = prd_pkg::ST_CHI;
               end
               prd_pkg::ST_CHI: begin
                  state_in = prd_pkg::ST_CLO;
               end
               prd_pkg::ST_CLO: begin
                  state_in = prd_pkg::ST_PRE;
               end
               default: begin
                  state_in = prd_pkg::ST_PRE;
               end
            endcase
         end
      end
   end

   // Frame fields, CRC, timer and job generation
   always_comb begin
      ftype_in    = ftype_ff;
      fseq_in     = fseq_ff;
      flen_in     = flen_ff;
      seen_in     = seen_ff;
      crc_in      = crc_ff;
      crc_high_in = crc_high_ff;
      left_in     = left_ff;
      armed_in    = armed_ff;
      job_push    = 1'b0;
      job         = '0;
      if (accept) begin
         if (req_ch.command) begin
            // timer tick
            if (armed_ff) begin
               if (tick_fire) begin
                  left_in  = '0;
                  armed_in = 1'b0;
                  job_push = 1'b1;
                  job.resp = prd_pkg::RESP_NACK;
                  job.data = cfg.err_timeout;
                  job.seq  = fseq_ff;
               end else begin
                  left_in = left_ff - TICK_WIDTH'(1);
               end
            end
         end else begin
            case (state_ff)
               prd_pkg::ST_PRE: begin
                  if (c == cfg.preamble) begin
                     fseq_in  = '0;
                     left_in  = timeout_load;
                     armed_in = 1'b1;
                  end
               end
               prd_pkg::ST_GARBAGE: begin
                  if (c == cfg.preamble) begin
                     job_push = 1'b1;
                     job.resp = prd_pkg::RESP_NACK;
                     job.data = cfg.err_stray;
                     job.seq  = 4'h0;
                     fseq_in  = '0;
                     left_in  = timeout_load;
                     armed_in = 1'b1;
                  end
               end
               prd_pkg::ST_HHI: begin
                  ftype_in = c[7:6];
                  fseq_in  = c[5:2];
                  flen_in  = {8'h00, c[1:0]};
                  crc_in   = prd_pkg::crc_step(prd_pkg::CRC_INIT, c);
               end
               prd_pkg::ST_HLO: begin
                  // length = (l-1)*256 + c + 1
                  flen_in  = {flen_ff[1:0] - 2'd1, 8'h00} + {2'b00, c} + 10'd1;
                  crc_in   = prd_pkg::crc_step(crc_ff, c);
                  seen_in  = '0;
               end
               prd_pkg::ST_DATA: begin
                  job_push       = 1'b1;
                  job.is_payload = 1'b1;
                  job.data       = c;
                  crc_in         = prd_pkg::crc_step(crc_ff, c);
                  seen_in        = seen_ff + 10'd1;
               end
               prd_pkg::ST_CHI: begin
                  crc_high_in = c;
               end
               prd_pkg::ST_CLO: begin
                  armed_in        = 1'b0;
                  left_in         = '0;
                  job_push        = 1'b1;
                  job.has_verdict = 1'b1;
                  job.ptype       = ftype_ff;
                  job.seq         = fseq_ff;
                  job.length      = flen_ff;
                  job.good        = crc_match;
                  job.data        = cfg.err_crc;
                  if (!crc_match) begin
                     job.resp = prd_pkg::RESP_NACK;
                  end else if (ftype_ff == cfg.req_ack_code && ftype_ff != cfg.ack_code &&
                               ftype_ff != cfg.nack_code) begin
                     job.resp = prd_pkg::RESP_ACK;
                  end else begin
                     job.resp = prd_pkg::RESP_NONE;
                  end
               end
               default: begin
                  job_push = 1'b0;
               end
            endcase
         end
      end
   end

   // Parser registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= prd_pkg::ST_PRE;
         ftype_ff    <= '0;
         fseq_ff     <= '0;
         flen_ff     <= '0;
         seen_ff     <= '0;
         crc_ff      <= prd_pkg::CRC_INIT;
         crc_high_ff <= '0;
         left_ff     <= '0;
         armed_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         ftype_ff    <= ftype_in;
         fseq_ff     <= fseq_in;
         flen_ff     <= flen_in;
         seen_ff     <= seen_in;
         crc_ff      <= crc_in;
         crc_high_ff <= crc_high_in;
         left_ff     <= left_in;
         armed_ff    <= armed_in;
      end
   end

endmodule

@@ sv/prd_queue.sv @@
// Job queue: small register FIFO between the parser and the result sequencer.
module prd_queue #(
   parameter int DEPTH = prd_pkg::JOB_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  prd_pkg::job_type push_job,
   input  logic             pop,
   output logic             full,
   output logic             head_valid,
   output prd_pkg::job_type head_job
);

   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] LAST_PTR = PTR_WIDTH'(DEPTH - 1);

   prd_pkg::job_type        entry_ff [DEPTH];
   logic [PTR_WIDTH-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]    count_ff, count_in;
   logic                    do_push, do_pop;

   assign full       = (count_ff == CNT_WIDTH'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_WIDTH'(1);
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_WIDTH'(1);
      if (do_push && !do_pop)      count_in = count_ff + CNT_WIDTH'(1);
      else if (!do_push && do_pop) count_in = count_ff - CNT_WIDTH'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_job;
   end

endmodule

@@ sv/prd_back.sv @@
// Back end: expands each job into result transfers and builds ACK/NACK frames.
module prd_back (
   input  logic             clock,
   input  logic             reset,
   input  prd_pkg::cfg_type cfg,
   input  logic             head_valid,
   input  prd_pkg::job_type head_job,
   output logic             pop,
   prd_rsp_if.source        rsp_ch
);

   // Byte positions inside a response frame
   localparam logic [2:0] POS_PRE  = 3'd0;
   localparam logic [2:0] POS_HDR  = 3'd1;
   localparam logic [2:0] POS_B2   = 3'd2;
   localparam logic [2:0] POS_B3   = 3'd3;
   localparam logic [2:0] POS_B4   = 3'd4;
   localparam logic [2:0] POS_B5   = 3'd5;

   logic [2:0]          step_ff, step_in;
   logic [15:0]         crc_ff, crc_in;
   prd_pkg::result_type out_ff, out_in;
   logic                out_valid_ff, out_valid_in;

   logic [2:0]          eff_step;
   logic [2:0]          pos;
   logic                advance;
   logic                is_nack;
   logic [7:0]          hdr;
   prd_pkg::result_type item;

   assign advance  = head_valid && (!out_valid_ff || rsp_ch.ready);
   // jobs without a verdict start at the first response byte
   assign eff_step = (step_ff == 3'd0 && !head_job.has_verdict && !head_job.is_payload) ?
                     3'd1 : step_ff;
   assign pos      = eff_step - 3'd1;
   assign is_nack  = (head_job.resp == prd_pkg::RESP_NACK);
   assign hdr      = is_nack ? {cfg.nack_code, head_job.seq, 2'b01} :
                               {cfg.ack_code, head_job.seq, 2'b00};

   // Result for the current step
   always_comb begin
      item = '0;
      if (head_job.is_payload) begin
         item.kind       = prd_pkg::KIND_PAYLOAD;
         item.byte_value = head_job.data;
         item.last       = 1'b1;
      end else if (eff_step == 3'd0) begin
         item.kind           = prd_pkg::KIND_VERDICT;
         item.packet_type    = head_job.ptype;
         item.sequence_res   = head_job.seq;
         item.payload_length = head_job.length;
         item.crc_good       = head_job.good;
         item.last           = (head_job.resp == prd_pkg::RESP_NONE);
      end else begin
         item.kind = prd_pkg::KIND_TX;
         case (pos)
            POS_PRE: item.byte_value = cfg.preamble;
            POS_HDR: item.byte_value = hdr;
            POS_B2:  item.byte_value = is_nack ? 8'h00 : crc_ff[15:8];
            POS_B3:  item.byte_value = is_nack ? head_job.data : crc_ff[7:0];
            POS_B4:  item.byte_value = crc_ff[15:8];
            POS_B5:  item.byte_value = crc_ff[7:0];
            default: item.byte_value = 8'h00;
         endcase
         item.last = is_nack ? (pos == POS_B5) : (pos == POS_B3);
      end
   end

   assign pop = advance && item.last;

   // Step counter, response CRC and output register
   always_comb begin
      step_in      = step_ff;
      crc_in       = crc_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_in       = item;
         out_valid_in = 1'b1;
         step_in      = pop ? 3'd0 : eff_step + 3'd1;
         if (!head_job.is_payload && eff_step != 3'd0) begin
            if (pos == POS_PRE) begin
               crc_in = prd_pkg::CRC_INIT;
            end else if (pos == POS_HDR ||
                         (is_nack && (pos == POS_B2 || pos == POS_B3))) begin
               crc_in = prd_pkg::crc_step(crc_ff, item.byte_value);
            end
         end
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
      out_ff <= out_in;
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.kind           = out_ff.kind;
   assign rsp_ch.byte_value     = out_ff.byte_value;
   assign rsp_ch.packet_type    = out_ff.packet_type;
   assign rsp_ch.sequence_res   = out_ff.sequence_res;
   assign rsp_ch.payload_length = out_ff.payload_length;
   assign rsp_ch.crc_good       = out_ff.crc_good;
   assign rsp_ch.last           = out_ff.last;

endmodule

@@ sv/packet_receive_deframer.sv @@
// Top level: packet receive deframer with configuration registers and checks.
//
// req_ch carries one line byte (command 0) or one timer tick (command 1) per
// transfer. rsp_ch returns the results: payload bytes as they arrive, a verdict
// after the second CRC byte, and the bytes of NACK or empty ACK frames to send.
// The last result caused by one request has last set; requests that cause no
// result (ignored bytes, header bytes, ticks that do not expire) return nothing.
// csr_* writes one configuration register per cycle; write only while idle.
//
// Timing: a request's job is registered in the job queue, and its first result
// is then registered in the output register of the result sequencer.
// Throughput: the parser takes one request per cycle while the job queue has
// room; the result sequencer sends one result per cycle while the receiver is
// ready, so a frame end with a NACK gives it seven results to send. The
// sequencer's one-result-per-cycle output register sets the sustained rate.
// Reset (synchronous) returns the parser to waiting for a preamble, empties the
// job queue and loads the register defaults. When the receiver stalls, the
// queue fills and then req_ch.ready drops; no result is lost.
module packet_receive_deframer #(
   parameter int TICK_WIDTH = prd_pkg::TICK_WIDTH_DEF,
   parameter int JOB_DEPTH  = prd_pkg::JOB_QUEUE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   prd_req_if.sink                              req_ch,
   prd_rsp_if.source                            rsp_ch,
   input  logic                                 csr_wr_en,
   input  logic [prd_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [prd_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   prd_pkg::cfg_type cfg_ff, cfg_in;
   prd_pkg::job_type push_job, head_job;
   logic             job_push, q_full, head_valid, job_pop;

   // Configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            prd_pkg::CSR_PREAMBLE:     cfg_in.preamble      = csr_wdata[7:0];
            prd_pkg::CSR_TIMEOUT:      cfg_in.timeout_ticks = csr_wdata;
            prd_pkg::CSR_ACK_CODE:     cfg_in.ack_code      = csr_wdata[1:0];
            prd_pkg::CSR_NACK_CODE:    cfg_in.nack_code     = csr_wdata[1:0];
            prd_pkg::CSR_REQ_ACK_CODE: cfg_in.req_ack_code  = csr_wdata[1:0];
            prd_pkg::CSR_ERR_STRAY:    cfg_in.err_stray     = csr_wdata[7:0];
            prd_pkg::CSR_ERR_CRC:      cfg_in.err_crc       = csr_wdata[7:0];
            prd_pkg::CSR_ERR_TIMEOUT:  cfg_in.err_timeout   = csr_wdata[7:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cfg_ff <= prd_pkg::CFG_RESET;
      else       cfg_ff <= cfg_in;
   end

   prd_front #(.TICK_WIDTH(TICK_WIDTH)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .cfg      (cfg_ff),
      .q_full   (q_full),
      .job_push (job_push),
      .job      (push_job)
   );

   prd_queue #(.DEPTH(JOB_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_job   (push_job),
      .pop        (job_pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   prd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (job_pop),
      .rsp_ch     (rsp_ch)
   );

   // A job is never issued into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      job_push |-> !q_full)
      else $error("job issued into full queue");

   // A payload byte always closes its request's results
   a_payload_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.kind == prd_pkg::KIND_PAYLOAD) |-> rsp_ch.last)
      else $error("payload result without last");

   // A bad CRC verdict is always followed by a NACK frame
   a_bad_crc_nack: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.kind == prd_pkg::KIND_VERDICT && !rsp_ch.crc_good)
      |-> !rsp_ch.last)
      else $error("bad CRC verdict not followed by NACK");

endmodule

@@ tb/packet_receive_deframer_test.sv @@
// Testbench: packet receive deframer checked against a behavioral predictor.
`timescale 1ns / 100ps

module packet_receive_deframer_test;

   localparam int PERIOD        = 20;
   localparam int RESET_CYCLES  = 10;
   localparam int SETTLE_CYCLES = 10;
   localparam int HOLD_CYCLES   = 200;
   localparam int LIMIT_CYCLES  = 400000;
   localparam int PHASE_ITEMS   = 22;
   localparam int PHASES        = 5;

   // Source of each directed row: a literal byte, a tick, or CRC bytes of the open frame
   typedef enum logic [2:0] {
      ROW_BYTE,
      ROW_TICK,
      ROW_CRC_HI,
      ROW_CRC_LO,
      ROW_CRC_BAD
   } row_src_type;

   typedef struct packed {
      row_src_type src;
      logic [7:0]  data;
      logic        typed;
      logic [2:0]  want_count;
      logic [1:0]  want_kind;
      logic [7:0]  want_byte;
   } stim_row_type;

   // Directed frames, run with the reset settings and a one-tick timeout
   localparam stim_row_type DIRECTED_ROWS [24] = '{
      '{ROW_TICK,    8'h00, 1'b1, 3'd0, prd_pkg::KIND_PAYLOAD, 8'h00},  // tick while idle
      '{ROW_BYTE,    8'h00, 1'b1, 3'd0, prd_pkg::KIND_PAYLOAD, 8'h00},  // garbage
      '{ROW_BYTE,    8'hFF, 1'b1, 3'd0, prd_pkg::KIND_PAYLOAD, 8'h00},  // ignored
      '{ROW_BYTE,    8'h5A, 1'b1, 3'd6, prd_pkg::KIND_TX,      8'h5A},  // stray preamble
      '{ROW_BYTE,    8'hCD, 1'b1, 3'd0, prd_pkg::KIND_PAYLOAD, 8'h00},  // type 3, seq 3, l 1
      '{ROW_BYTE,    8'h01, 1'b1, 3'd0, prd_pkg::KIND_PAYLOAD, 8'h00},  // length 2
      '{ROW_BYTE,    8'h00, 1'b1, 3'd1, prd_pkg::KIND_PAYLOAD, 8'h00},
      '{ROW_BYTE,    8'h5A, 1'b1, 3'd1, prd_pkg::KIND_PAYLOAD, 8'h5A},  // preamble as payload
      '{ROW_CRC_HI,  8'h00, 1'b0, 3'd0, prd_pkg::KIND_PAYLOAD, 8'h00},
      '{ROW_CRC_LO,  8'h00, 1'b1, 3'd5, prd_pkg::KIND_VERDICT, 8'h00},  // verdict + ACK
      '{ROW_BYTE,    8'h5A, 1'b1, 3'd0, prd_pkg::KIND_PAYLOAD, 8'h00},
      '{ROW_BYTE,    8'h3C, 1'b1, 3'd0, prd_pkg::KIND_PAYLOAD, 8'h00},  // seq 15, no payload
      '{ROW_CRC_HI,  8'h00, 1'b0, 3'd0, prd_pkg::KIND_PAYLOAD, 8'h00},
      '{ROW_CRC_BAD, 8'h00, 1'b1, 3'd7, prd_pkg::KIND_VERDICT, 8'h00},  // verdict + NACK
      '{ROW_TICK,    8'h00, 1'b1, 3'd0, prd_pkg::KIND_PAYLOAD, 8'h00},  // timer disarmed
      '{ROW_BYTE,    8'h5A, 1'b1, 3'd0, prd_pkg::KIND_PAYLOAD, 8'h00},
      '{ROW_BYTE,    8'h82, 1'b1, 3'd0, prd_pkg::KIND_PAYLOAD, 8'h00},  // type 2, l 2
      '{ROW_TICK,    8'h00, 1'b1, 3'd6, prd_pkg::KIND_TX,      8'h5A},  // timeout NACK
      '{ROW_BYTE,    8'h5A, 1'b1, 3'd0, prd_pkg::KIND_PAYLOAD, 8'h00},
      '{ROW_BYTE,    8'h41, 1'b1, 3'd0, prd_pkg::KIND_PAYLOAD, 8'h00},  // type 1, l 1
      '{ROW_BYTE,    8'h00, 1'b1, 3'd0, prd_pkg::KIND_PAYLOAD, 8'h00},  // length 1
      '{ROW_BYTE,    8'hA5, 1'b1, 3'd1, prd_pkg::KIND_PAYLOAD, 8'hA5},
      '{ROW_CRC_HI,  8'h00, 1'b0, 3'd0, prd_pkg::KIND_PAYLOAD, 8'h00},
      '{ROW_CRC_LO,  8'h00, 1'b1, 3'd1, prd_pkg::KIND_VERDICT, 8'h00}   // verdict only
   };

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                csr_wr_en;
   logic [prd_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [prd_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata;

   prd_req_if req_ch ();
   prd_rsp_if rsp_ch ();

   packet_receive_deframer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(PERIOD / 2) clock = ~clock;

   // Predictor copy of the settings and the parser state
   prd_pkg::cfg_type         shadow_cfg;
   prd_pkg::parse_state_type pred_state;
   logic [1:0]               fr_type;
   logic [3:0]               fr_seq;
   logic [9:0]               fr_len;
   logic [9:0]               fr_count;
   logic [15:0]              fr_crc;
   logic [7:0]               fr_crc_hi;
   logic [15:0]              ticks_left;
   logic                     timer_on;

   prd_pkg::result_type awaited_results [$];
   prd_pkg::result_type step_results [$];
   prd_pkg::result_type step_first;
   int                  step_count;

   int mismatch_count = 0;
   int results_checked = 0;
   int item_count = 0;
   int cycle_count = 0;
   int req_gap_max = 3;
   int rsp_stall_max = 3;
   int tick_percent = 0;
   bit hold_request = 1'b0;

   task automatic report_mismatch(input string text);
      $display("[%0t] MISMATCH: %s", $time, text);
      mismatch_count++;
   endtask

   // CRC-16-CCITT, polynomial 0x1021, MSB first, one bit at a time
   function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] value);
      logic [15:0] c;
      c = crc ^ {value, 8'h00};
      for (int i = 0; i < 8; i++) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
      return c;
   endfunction

   function automatic void add_result(logic [1:0] kind, logic [7:0] value, logic [1:0] ptype,
                                      logic [3:0] seq, logic [9:0] len, logic good);
      prd_pkg::result_type r;
      r.kind           = kind;
      r.byte_value     = value;
      r.packet_type    = ptype;
      r.sequence_res   = seq;
      r.payload_length = len;
      r.crc_good       = good;
      r.last           = 1'b0;
      step_results.push_back(r);
   endfunction

   function automatic void add_tx(logic [7:0] value);
      add_result(prd_pkg::KIND_TX, value, 2'd0, 4'd0, 10'd0, 1'b0);
   endfunction

   function automatic void add_nack(logic [7:0] err, logic [3:0] seq);
      logic [7:0]  head;
      logic [15:0] crc;
      head = {shadow_cfg.nack_code, seq, 2'b01};
      crc  = crc16_update(crc16_update(crc16_update(prd_pkg::CRC_INIT, head), 8'h00), err);
      add_tx(shadow_cfg.preamble);
      add_tx(head);
      add_tx(8'h00);
      add_tx(err);
      add_tx(crc[15:8]);
      add_tx(crc[7:0]);
   endfunction

   function automatic void add_ack(logic [3:0] seq);
      logic [7:0]  head;
      logic [15:0] crc;
      head = {shadow_cfg.ack_code, seq, 2'b00};
      crc  = crc16_update(prd_pkg::CRC_INIT, head);
      add_tx(shadow_cfg.preamble);
      add_tx(head);
      add_tx(crc[15:8]);
      add_tx(crc[7:0]);
   endfunction

   function automatic void open_frame();
      fr_seq     = 4'd0;
      ticks_left = shadow_cfg.timeout_ticks;
      timer_on   = 1'b1;
      pred_state = prd_pkg::ST_HHI;
   endfunction

   function automatic void parse_byte(logic [7:0] b);
      logic good;
      case (pred_state)
         prd_pkg::ST_PRE: begin
            if (b == shadow_cfg.preamble) open_frame();
            else pred_state = prd_pkg::ST_GARBAGE;
         end
         prd_pkg::ST_GARBAGE: begin
            if (b == shadow_cfg.preamble) begin
               add_nack(shadow_cfg.err_stray, 4'd0);
               open_frame();
            end
         end
         prd_pkg::ST_HHI: begin
            fr_type    = b[7:6];
            fr_seq     = b[5:2];
            fr_len     = {8'h00, b[1:0]};
            fr_crc     = crc16_update(prd_pkg::CRC_INIT, b);
            pred_state = (b[1:0] == 2'd0) ? prd_pkg::ST_CHI : prd_pkg::ST_HLO;
         end
         prd_pkg::ST_HLO: begin
            // length is (l-1)*256 + c + 1
            fr_len     = {fr_len[1:0] - 2'd1, 8'h00} + {2'b00, b} + 10'd1;
            fr_crc     = crc16_update(fr_crc, b);
            fr_count   = 10'd0;
            pred_state = prd_pkg::ST_DATA;
         end
         prd_pkg::ST_DATA: begin
            add_result(prd_pkg::KIND_PAYLOAD, b, 2'd0, 4'd0, 10'd0, 1'b0);
            fr_crc   = crc16_update(fr_crc, b);
            fr_count = fr_count + 10'd1;
            if (fr_count >= fr_len) pred_state = prd_pkg::ST_CHI;
         end
         prd_pkg::ST_CHI: begin
            fr_crc_hi  = b;
            pred_state = prd_pkg::ST_CLO;
         end
         prd_pkg::ST_CLO: begin
            good       = ({fr_crc_hi, b} == fr_crc);
            timer_on   = 1'b0;
            ticks_left = 16'd0;
            add_result(prd_pkg::KIND_VERDICT, 8'h00, fr_type, fr_seq, fr_len, good);
            if (!good) add_nack(shadow_cfg.err_crc, fr_seq);
            else if (fr_type == shadow_cfg.req_ack_code && fr_type != shadow_cfg.ack_code &&
                     fr_type != shadow_cfg.nack_code) add_ack(fr_seq);
            pred_state = prd_pkg::ST_PRE;
         end
         default: pred_state = prd_pkg::ST_PRE;
      endcase
   endfunction

   function automatic void count_tick();
      if (timer_on) begin
         if (ticks_left <= 16'd1) begin
            ticks_left = 16'd0;
            timer_on   = 1'b0;
            add_nack(shadow_cfg.err_timeout, fr_seq);
            pred_state = prd_pkg::ST_PRE;
         end else begin
            ticks_left = ticks_left - 16'd1;
         end
      end
   endfunction

   // Results expected from one request, last flag on the final one
   function automatic void deframe_step(logic cmd, logic [7:0] b);
      step_results.delete();
      if (cmd) count_tick();
      else parse_byte(b);
      step_count = step_results.size();
      if (step_count > 0) begin
         step_results[step_count - 1].last = 1'b1;
         step_first = step_results[0];
      end
      foreach (step_results[i]) awaited_results.push_back(step_results[i]);
   endfunction

   function automatic void predictor_reset();
      shadow_cfg = prd_pkg::CFG_RESET;
      pred_state = prd_pkg::ST_PRE;
      fr_type    = 2'd0;
      fr_seq     = 4'd0;
      fr_len     = 10'd0;
      fr_count   = 10'd0;
      fr_crc     = prd_pkg::CRC_INIT;
      fr_crc_hi  = 8'h00;
      ticks_left = 16'd0;
      timer_on   = 1'b0;
   endfunction

   task automatic write_register(input logic [prd_pkg::CSR_INDEX_WIDTH-1:0] index,
                                 input logic [prd_pkg::CSR_DATA_WIDTH-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic apply_settings(input prd_pkg::cfg_type s);
      write_register(prd_pkg::CSR_PREAMBLE, {8'h00, s.preamble});
      write_register(prd_pkg::CSR_TIMEOUT, s.timeout_ticks);
      write_register(prd_pkg::CSR_ACK_CODE, {14'h0000, s.ack_code});
      write_register(prd_pkg::CSR_NACK_CODE, {14'h0000, s.nack_code});
      write_register(prd_pkg::CSR_REQ_ACK_CODE, {14'h0000, s.req_ack_code});
      write_register(prd_pkg::CSR_ERR_STRAY, {8'h00, s.err_stray});
      write_register(prd_pkg::CSR_ERR_CRC, {8'h00, s.err_crc});
      write_register(prd_pkg::CSR_ERR_TIMEOUT, {8'h00, s.err_timeout});
      shadow_cfg = s;
   endtask

   // One request transfer; valid stays high when the next one follows at once
   task automatic send_item(input logic cmd, input logic [7:0] b);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.command <= cmd;
      req_ch.rx_byte <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      deframe_step(cmd, b);
      item_count++;
   endtask

   task automatic send_line_byte(input logic [7:0] b);
      if ($urandom_range(0, 99) < tick_percent) send_item(1'b1, 8'($urandom_range(0, 255)));
      send_item(1'b0, b);
   endtask

   task automatic send_frame(input logic [1:0] len_code, input logic [7:0] len_low,
                             input bit corrupt);
      logic [7:0]  head;
      logic [7:0]  data;
      logic [15:0] crc;
      int          count;
      head       = 8'($urandom_range(0, 255));
      head[1:0]  = len_code;
      count      = (len_code == 2'd0) ? 0 : (int'(len_code) - 1) * 256 + int'(len_low) + 1;
      send_line_byte(shadow_cfg.preamble);
      send_line_byte(head);
      crc = crc16_update(prd_pkg::CRC_INIT, head);
      if (len_code != 2'd0) begin
         send_line_byte(len_low);
         crc = crc16_update(crc, len_low);
      end
      repeat (count) begin
         data = 8'($urandom_range(0, 255));
         send_line_byte(data);
         crc = crc16_update(crc, data);
      end
      if (corrupt) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
      send_line_byte(crc[15:8]);
      send_line_byte(crc[7:0]);
   endtask

   // Frame cut short; the next frame's bytes land in its payload
   task automatic send_truncated();
      logic [7:0] head;
      head      = 8'($urandom_range(0, 255));
      head[1:0] = 2'd1;
      send_line_byte(shadow_cfg.preamble);
      send_line_byte(head);
      send_line_byte(8'($urandom_range(10, 30)));
      repeat ($urandom_range(0, 3)) send_line_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic send_noise();
      repeat ($urandom_range(1, 4)) begin
         if ($urandom_range(0, 3) == 0) send_item(1'b1, 8'($urandom_range(0, 255)));
         else send_item(1'b0, 8'($urandom_range(0, 255)));
      end
   endtask

   // Wait until every expected result has come, then let the pipeline empty
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Result receiver: random stalls, one long hold-off on request
   initial begin : result_sink
      int stall;
      rsp_ch.ready = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_request) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end
         stall = $urandom_range(0, rsp_stall_max);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
      end
   end

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                   results_checked, name, got, want));
   endtask

   // Compare each result transfer with the oldest expectation
   always @(posedge clock) begin : result_check
      prd_pkg::result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (awaited_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d byte %02h",
                                      rsp_ch.kind, rsp_ch.byte_value));
         end else begin
            want = awaited_results.pop_front();
            check_field("kind", rsp_ch.kind, want.kind);
            check_field("byte_value", rsp_ch.byte_value, want.byte_value);
            check_field("packet_type", rsp_ch.packet_type, want.packet_type);
            check_field("sequence_res", rsp_ch.sequence_res, want.sequence_res);
            check_field("payload_length", rsp_ch.payload_length, want.payload_length);
            check_field("crc_good", rsp_ch.crc_good, want.crc_good);
            check_field("last", rsp_ch.last, want.last);
         end
         results_checked++;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin : stimulus
      stim_row_type     row;
      prd_pkg::cfg_type settings;
      prd_pkg::cfg_type phase_settings [PHASES];
      int               phase_gap [PHASES];
      int               phase_stall [PHASES];
      int               phase_ticks [PHASES];
      int               phase_end;
      int               pick;

      // Varied register settings across the phases; preamble, ACK and NACK codes reach both extremes
      phase_settings[0] = '{8'h00, 16'hFFFF, 2'd0, 2'd1, 2'd3, 8'h00, 8'hFF, 8'h80};
      phase_settings[1] = '{8'hFF, 16'd3,    2'd3, 2'd2, 2'd1, 8'h7F, 8'h01, 8'hFE};
      phase_settings[2] = '{8'hA5, 16'd12,   2'd1, 2'd0, 2'd1, 8'h55, 8'hAA, 8'h33};
      phase_settings[3] = '{8'h5A, 16'd1,    2'd2, 2'd3, 2'd3, 8'hC3, 8'h3C, 8'hFF};
      phase_settings[4] = prd_pkg::CFG_RESET;
      phase_gap   = '{19, 19, 0, 5, 19};
      phase_stall = '{19, 0, 19, 5, 19};
      phase_ticks = '{10, 20, 15, 5, 3};

      req_ch.valid   = 1'b0;
      req_ch.command = 1'b0;
      req_ch.rx_byte = 8'h00;
      csr_wr_en      = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      predictor_reset();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed rows
      settings               = prd_pkg::CFG_RESET;
      settings.timeout_ticks = 16'd1;
      apply_settings(settings);
      for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
         row = DIRECTED_ROWS[i];
         case (row.src)
            ROW_TICK:    send_item(1'b1, 8'($urandom_range(0, 255)));
            ROW_CRC_HI:  send_item(1'b0, fr_crc[15:8]);
            ROW_CRC_LO:  send_item(1'b0, fr_crc[7:0]);
            ROW_CRC_BAD: send_item(1'b0, ~fr_crc[7:0]);
            default:     send_item(1'b0, row.data);
         endcase
         if (row.typed && (step_count != row.want_count ||
             (step_count > 0 && (step_first.kind != row.want_kind ||
                                 step_first.byte_value != row.want_byte))))
            report_mismatch($sformatf("directed row %0d: predicted %0d results", i,
                                      step_count));
      end

      // Random frames, noise and broken frames under each setting
      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         apply_settings(phase_settings[p]);
         req_gap_max   = phase_gap[p];
         rsp_stall_max = phase_stall[p];
         tick_percent  = phase_ticks[p];
         phase_end     = item_count + PHASE_ITEMS;
         while (item_count < phase_end) begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
               send_frame(2'($urandom_range(0, 1)), 8'($urandom_range(0, 7)),
                          $urandom_range(0, 4) == 0);
            else if (pick == 7)
               send_noise();
            else if (pick == 8)
               send_truncated();
            else
               send_frame(2'd1, 8'($urandom_range(8, 40)), $urandom_range(0, 4) == 0);
         end
      end

      // Back-to-back stretch: receiver hold-off during a long frame, then a bad one
      wait_idle();
      apply_settings(prd_pkg::CFG_RESET);
      req_gap_max   = 0;
      rsp_stall_max = 0;
      tick_percent  = 0;
      hold_request  = 1'b1;
      send_frame(2'd1, 8'd39, 1'b0);
      send_frame(2'd1, 8'd3, 1'b1);

      wait_idle();
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/prd_pkg.sv
sv/prd_ifs.sv
sv/prd_front.sv
sv/prd_queue.sv
sv/prd_back.sv
sv/packet_receive_deframer.sv
tb/packet_receive_deframer_test.sv
